// File: src/rfba_pkg.sv
// ----------------------------------------------------------------------------
// rfba_pkg
// shared types, codes and defaults of the rotating framebuffer blit addresser
// ----------------------------------------------------------------------------
package rfba_pkg;

    // default geometry, overridable at the top level
    localparam int MAX_DIM_DEF       = 1024;
    localparam int VGA_ROW_BYTES_DEF = 960;
    localparam int VGA_COLS_DEF      = 480;
    localparam int VGA_ROWS_DEF      = 640;

    // byte stride of one replicated pixel pair along a vga row
    localparam int VGA_PAIR_STRIDE = 2;

    // configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int DIM_W   = 10;
    localparam int PITCH_W = 14;
    localparam int LIN_W   = 20;

    // register reset values
    localparam logic [DIM_W-1:0]   SRC_WIDTH_RST    = 10'd320;
    localparam logic [DIM_W-1:0]   SRC_HEIGHT_RST   = 10'd240;
    localparam logic [PITCH_W-1:0] X_PITCH_RST      = 14'd2;
    localparam logic [PITCH_W-1:0] Y_PITCH_RST      = 14'd480;
    localparam logic [DIM_W-1:0]   PANEL_WIDTH_RST  = 10'd240;
    localparam logic [DIM_W-1:0]   PANEL_HEIGHT_RST = 10'd320;

    typedef enum logic [2:0] {
        MODE_PORT_LINEAR = 3'd0,
        MODE_PORT_VGA    = 3'd1,
        MODE_VGA_LEFT    = 3'd2,
        MODE_VGA_RIGHT   = 3'd3,
        MODE_LAND_LEFT   = 3'd4,
        MODE_LAND_RIGHT  = 3'd5,
        MODE_PORT_LEFT   = 3'd6,
        MODE_PORT_RIGHT  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE         = 3'd0,
        REG_SRC_WIDTH    = 3'd1,
        REG_SRC_HEIGHT   = 3'd2,
        REG_X_PITCH      = 3'd3,
        REG_Y_PITCH      = 3'd4,
        REG_PANEL_WIDTH  = 3'd5,
        REG_PANEL_HEIGHT = 3'd6
    } t_reg_idx;

    // configuration as seen by the datapath
    typedef struct packed {
        t_mode                     mode;
        logic [DIM_W-1:0]          src_width;
        logic [DIM_W-1:0]          src_height;
        logic signed [PITCH_W-1:0] x_pitch;
        logic signed [PITCH_W-1:0] y_step;     // y pitch, low bit cleared
        logic [LIN_W-1:0]          lin_count;  // panel_width * panel_height
        logic [31:0]               base_left;  // x_pitch * (panel_width - 1)
        logic [31:0]               base_right; // y_pitch * (panel_height - 1)
    } t_cfg;

    // position flags of the pixel under work
    typedef struct packed {
        logic             raster_eof;
        logic             lin_ok;
        logic             lin_eof;
        logic [LIN_W-1:0] lin_n;
    } t_pos;

    // results of one pixel
    typedef struct packed {
        logic [1:0]  nres;
        logic [31:0] off0;
        logic [31:0] off1;
        logic [31:0] data;
        logic        wide;
        logic        eof;
    } t_res;

endpackage

// File: src/rfba_if.sv
// ----------------------------------------------------------------------------
// rfba_if
// valid/ready channels for source pixels and framebuffer writes
// ----------------------------------------------------------------------------
interface rfba_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface rfba_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] byte_offset;
    logic [31:0]        write_data;
    logic               wide;
    logic               end_of_frame;
    logic               last;

    modport source (
        output valid, output byte_offset, output write_data, output wide,
        output end_of_frame, output last, input ready
    );
    modport sink (
        input valid, input byte_offset, input write_data, input wide,
        input end_of_frame, input last, output ready
    );
endinterface

// File: src/rfba_cfg.sv
// ----------------------------------------------------------------------------
// rfba_cfg
// apb register file with registered per-frame products
// ----------------------------------------------------------------------------
module rfba_cfg
    import rfba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_mode                     r_mode;
    logic [DIM_W-1:0]          r_src_width;
    logic [DIM_W-1:0]          r_src_height;
    logic [PITCH_W-1:0]        r_x_pitch;
    logic [PITCH_W-1:0]        r_y_pitch;
    logic [DIM_W-1:0]          r_panel_width;
    logic [DIM_W-1:0]          r_panel_height;
    logic [LIN_W-1:0]          r_lin_count;
    logic [31:0]               r_base_left;
    logic [31:0]               r_base_right;

    t_reg_idx                  w_idx;
    logic                      w_wr;
    logic signed [DIM_W:0]     w_pw_m1;
    logic signed [DIM_W:0]     w_ph_m1;
    logic signed [PITCH_W+DIM_W:0] w_left;
    logic signed [PITCH_W+DIM_W:0] w_right;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_PORT_LINEAR;
            r_src_width    <= SRC_WIDTH_RST;
            r_src_height   <= SRC_HEIGHT_RST;
            r_x_pitch      <= X_PITCH_RST;
            r_y_pitch      <= Y_PITCH_RST;
            r_panel_width  <= PANEL_WIDTH_RST;
            r_panel_height <= PANEL_HEIGHT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODE:         r_mode         <= t_mode'(pwdata[2:0]);
                REG_SRC_WIDTH:    r_src_width    <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT:   r_src_height   <= pwdata[DIM_W-1:0];
                REG_X_PITCH:      r_x_pitch      <= pwdata[PITCH_W-1:0];
                REG_Y_PITCH:      r_y_pitch      <= pwdata[PITCH_W-1:0];
                REG_PANEL_WIDTH:  r_panel_width  <= pwdata[DIM_W-1:0];
                REG_PANEL_HEIGHT: r_panel_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // per-frame products, refreshed every cycle from the registers
    assign w_pw_m1 = $signed({1'b0, r_panel_width}) - 11'sd1;
    assign w_ph_m1 = $signed({1'b0, r_panel_height}) - 11'sd1;
    assign w_left  = $signed(r_x_pitch) * w_pw_m1;
    assign w_right = $signed(r_y_pitch) * w_ph_m1;

    always_ff @(posedge i_clk) begin
        r_lin_count  <= LIN_W'(r_panel_width) * LIN_W'(r_panel_height);
        r_base_left  <= {{(31-PITCH_W-DIM_W){w_left[PITCH_W+DIM_W]}}, w_left};
        r_base_right <= {{(31-PITCH_W-DIM_W){w_right[PITCH_W+DIM_W]}}, w_right};
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_MODE:         prdata = 32'(r_mode);
            REG_SRC_WIDTH:    prdata = 32'(r_src_width);
            REG_SRC_HEIGHT:   prdata = 32'(r_src_height);
            REG_X_PITCH:      prdata = 32'($signed(r_x_pitch));
            REG_Y_PITCH:      prdata = 32'($signed(r_y_pitch));
            REG_PANEL_WIDTH:  prdata = 32'(r_panel_width);
            REG_PANEL_HEIGHT: prdata = 32'(r_panel_height);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg            = '0;
        o_cfg.mode       = r_mode;
        o_cfg.src_width  = r_src_width;
        o_cfg.src_height = r_src_height;
        o_cfg.x_pitch    = r_x_pitch;
        o_cfg.y_step     = {r_y_pitch[PITCH_W-1:1], 1'b0};
        o_cfg.lin_count  = r_lin_count;
        o_cfg.base_left  = r_base_left;
        o_cfg.base_right = r_base_right;
    end

endmodule

// File: src/rfba_pos.sv
// ----------------------------------------------------------------------------
// rfba_pos
// raster and linear position counters
// ----------------------------------------------------------------------------
module rfba_pos
    import rfba_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_frame_start,
    input  t_cfg                       i_cfg,
    output logic [$clog2(MAX_DIM)-1:0] o_col,
    output logic [$clog2(MAX_DIM)-1:0] o_row,
    output t_pos                       o_pos
);

    localparam int CW = $clog2(MAX_DIM);

    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [LIN_W-1:0] r_lin;

    logic [CW-1:0]    w_col;
    logic [CW-1:0]    w_row;
    logic [LIN_W-1:0] w_lin;
    logic [31:0]      w_w_m1;
    logic [31:0]      w_h_m1;
    logic             w_last_col;
    logic             w_last_row;
    logic             w_raster_eof;
    logic             w_lin_ok;
    logic             w_lin_eof;

    // frame start restarts the counters ahead of this pixel
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;
    assign w_lin = i_frame_start ? '0 : r_lin;

    // a zero dimension wraps to the full counter range
    assign w_w_m1       = 32'(i_cfg.src_width) - 32'd1;
    assign w_h_m1       = 32'(i_cfg.src_height) - 32'd1;
    assign w_last_col   = w_col == w_w_m1[CW-1:0];
    assign w_last_row   = w_row == w_h_m1[CW-1:0];
    assign w_raster_eof = w_last_col && w_last_row;
    assign w_lin_ok     = w_lin < i_cfg.lin_count;
    assign w_lin_eof    = w_lin_ok
                          && ((21'(w_lin) + 21'd1) == {1'b0, i_cfg.lin_count});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_lin <= '0;
        end else if (i_step) begin
            if (w_lin_ok) begin
                r_lin <= w_lin + LIN_W'(1);
            end else begin
                r_lin <= w_lin;
            end
            if (w_raster_eof) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_last_col) begin
                r_col <= '0;
                r_row <= w_row + CW'(1);
            end else begin
                r_col <= w_col + CW'(1);
                r_row <= w_row;
            end
        end
    end

    assign o_col = w_col;
    assign o_row = w_row;

    always_comb begin
        o_pos            = '0;
        o_pos.raster_eof = w_raster_eof;
        o_pos.lin_ok     = w_lin_ok;
        o_pos.lin_eof    = w_lin_eof;
        o_pos.lin_n      = w_lin;
    end

endmodule

// File: src/rfba_addr.sv
// ----------------------------------------------------------------------------
// rfba_addr
// byte offsets and write data of one pixel per mode
// ----------------------------------------------------------------------------
module rfba_addr
    import rfba_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int VGA_ROW_BYTES = VGA_ROW_BYTES_DEF,
    parameter int VGA_COLS      = VGA_COLS_DEF,
    parameter int VGA_ROWS      = VGA_ROWS_DEF
) (
    input  t_cfg                       i_cfg,
    input  t_pos                       i_pos,
    input  logic [$clog2(MAX_DIM)-1:0] i_col,
    input  logic [$clog2(MAX_DIM)-1:0] i_row,
    input  logic [15:0]                i_pixel,
    output t_res                       o_res
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = PITCH_W + CW + 1;

    localparam logic [31:0] ROW_B   = 32'(VGA_ROW_BYTES);
    localparam logic [31:0] TWO_ROW = 32'(2 * VGA_ROW_BYTES);
    localparam logic [31:0] K_LEFT  =
        32'(2 * VGA_PAIR_STRIDE * (VGA_COLS - 1) - VGA_ROW_BYTES);
    localparam logic [31:0] K_RIGHT = 32'(VGA_ROW_BYTES * (VGA_ROWS - 2));

    logic [31:0]          w_c32;
    logic [31:0]          w_r32;
    logic [31:0]          w_cr;
    logic [31:0]          w_r4;
    logic signed [PW-1:0] w_xr;
    logic signed [PW-1:0] w_yc;
    logic [31:0]          w_xr32;
    logic [31:0]          w_yc32;
    logic [31:0]          w_lin2;
    logic [31:0]          w_rev2;
    logic [31:0]          w_vga_l;
    logic [31:0]          w_vga_r;

    assign w_c32 = 32'(i_col);
    assign w_r32 = 32'(i_row);
    assign w_cr  = w_c32 * TWO_ROW;
    assign w_r4  = {w_r32[29:0], 2'b00};

    // pitch terms of the rotated portrait writes
    assign w_xr   = $signed(i_cfg.x_pitch) * $signed({1'b0, i_row});
    assign w_yc   = $signed(i_cfg.y_step) * $signed({1'b0, i_col});
    assign w_xr32 = {{(32-PW){w_xr[PW-1]}}, w_xr};
    assign w_yc32 = {{(32-PW){w_yc[PW-1]}}, w_yc};

    assign w_lin2  = {11'b0, i_pos.lin_n, 1'b0};
    assign w_rev2  = (32'(i_cfg.lin_count) - 32'd1 - 32'(i_pos.lin_n)) << 1;
    assign w_vga_l = K_LEFT - w_r4 + w_cr;
    assign w_vga_r = K_RIGHT + w_r4 - w_cr;

    always_comb begin
        o_res      = '0;
        o_res.data = {16'b0, i_pixel};
        o_res.eof  = i_pos.raster_eof;
        case (i_cfg.mode) inside
            MODE_PORT_LINEAR, MODE_LAND_RIGHT: begin
                o_res.nres = i_pos.lin_ok ? 2'd1 : 2'd0;
                o_res.off0 = w_lin2;
                o_res.eof  = i_pos.lin_eof;
            end
            MODE_LAND_LEFT: begin
                o_res.nres = i_pos.lin_ok ? 2'd1 : 2'd0;
                o_res.off0 = w_rev2;
                o_res.eof  = i_pos.lin_eof;
            end
            MODE_VGA_LEFT, MODE_VGA_RIGHT: begin
                // 2x2 replication: two word writes one vga row apart
                o_res.nres = 2'd2;
                o_res.off0 = (i_cfg.mode == MODE_VGA_LEFT) ? w_vga_l : w_vga_r;
                o_res.off1 = o_res.off0 + ROW_B;
                o_res.data = {i_pixel, i_pixel};
                o_res.wide = 1'b1;
            end
            MODE_PORT_LEFT: begin
                o_res.nres = 2'd1;
                o_res.off0 = i_cfg.base_left - w_xr32 + w_yc32;
            end
            MODE_PORT_RIGHT: begin
                o_res.nres = 2'd1;
                o_res.off0 = i_cfg.base_right + w_xr32 - w_yc32;
            end
            default: begin
                o_res.nres = 2'd0;
            end
        endcase
    end

endmodule

// File: src/rfba_out.sv
// ----------------------------------------------------------------------------
// rfba_out
// result register that plays out one or two writes per pixel
// ----------------------------------------------------------------------------
module rfba_out
    import rfba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_res       i_res,
    output logic       o_can_take,
    rfba_out_if.source o_out
);

    logic        r_vld;
    logic        r_beat;
    logic        r_two;
    logic [31:0] r_off0;
    logic [31:0] r_off1;
    logic [31:0] r_data;
    logic        r_wide;
    logic        r_eof;

    logic        w_last;

    assign w_last     = !r_two || r_beat;
    assign o_can_take = !r_vld || (o_out.ready && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_beat <= 1'b0;
        end else if (o_can_take) begin
            r_vld  <= i_load && (i_res.nres != 2'd0);
            r_beat <= 1'b0;
        end else if (o_out.ready) begin
            r_beat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take) begin
            r_two  <= i_res.nres == 2'd2;
            r_off0 <= i_res.off0;
            r_off1 <= i_res.off1;
            r_data <= i_res.data;
            r_wide <= i_res.wide;
            r_eof  <= i_res.eof;
        end
    end

    assign o_out.valid        = r_vld;
    assign o_out.byte_offset  = r_beat ? r_off1 : r_off0;
    assign o_out.write_data   = r_data;
    assign o_out.wide         = r_wide;
    assign o_out.end_of_frame = r_eof;
    assign o_out.last         = w_last;

endmodule

// File: src/rotating_framebuffer_blit_addresser.sv
// ----------------------------------------------------------------------------
// rotating_framebuffer_blit_addresser
// turns raster rgb565 pixels into framebuffer write offsets and data
// ----------------------------------------------------------------------------
// usage
// - i_in carries source pixels in raster order; frame_start on a pixel
//   restarts the column, row and linear counters at that pixel
// - o_out carries framebuffer writes: byte offset from the base, data,
//   width flag, end of frame and last-write-of-pixel flag
// - the user writes registers over the apb port only while no transaction is
//   in flight; the block itself does not enforce this
// - a pixel taken is held in the input register, its writes are computed
//   from it and registered in the output register, which drives o_out
// - linear and rotated portrait modes give at most one write per pixel and run
//   at one pixel per cycle while o_out is ready; vga landscape modes give two
//   word writes per pixel; the single output register sends both in turn
// - pixels that give no write (portrait vga, linear count used up) still
//   advance the counters and leave the output empty
// - when o_out stalls the output register holds its write and the input
//   register fills behind it; i_in.ready drops once both are occupied
// - reset clears the counters and loads the register defaults; there is no
//   clearing pass, pixels are taken in the first cycle after reset
// ----------------------------------------------------------------------------
module rotating_framebuffer_blit_addresser
    import rfba_pkg::*;
#(
    parameter int MAX_DIM       = MAX_DIM_DEF,
    parameter int VGA_ROW_BYTES = VGA_ROW_BYTES_DEF,
    parameter int VGA_COLS      = VGA_COLS_DEF,
    parameter int VGA_ROWS      = VGA_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // pixel stream in, write stream out
    rfba_in_if.sink               i_in,
    rfba_out_if.source            o_out
);

    localparam int CW = $clog2(MAX_DIM);

    // input register
    logic        r_in_vld;
    logic [15:0] r_pixel;
    logic        r_frame_start;

    logic          w_can_take;
    logic          w_adv;
    t_cfg          w_cfg;
    t_pos          w_pos;
    t_res          w_res;
    logic [CW-1:0] w_col;
    logic [CW-1:0] w_row;

    // the pixel moves on whenever the output register can take its writes
    assign w_adv      = r_in_vld && w_can_take;
    assign i_in.ready = !r_in_vld || w_can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_pixel       <= i_in.pixel;
            r_frame_start <= i_in.frame_start;
        end
    end

    rfba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // counters step once per pixel leaving the input register
    rfba_pos #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_adv),
        .i_frame_start (r_frame_start),
        .i_cfg         (w_cfg),
        .o_col         (w_col),
        .o_row         (w_row),
        .o_pos         (w_pos)
    );

    // offsets: small pitch multipliers and constant row products
    rfba_addr #(
        .MAX_DIM       (MAX_DIM),
        .VGA_ROW_BYTES (VGA_ROW_BYTES),
        .VGA_COLS      (VGA_COLS),
        .VGA_ROWS      (VGA_ROWS)
    ) u_addr (
        .i_cfg   (w_cfg),
        .i_pos   (w_pos),
        .i_col   (w_col),
        .i_row   (w_row),
        .i_pixel (r_pixel),
        .o_res   (w_res)
    );

    // result register, one or two output transactions per pixel
    rfba_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_adv),
        .i_res      (w_res),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

endmodule
